// File: hdl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, codes, configuration types and the log2 mantissa table for
// the thermistor temperature pipeline.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // field and fixed-point widths
    localparam int CODE_BITS      = 16;
    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int RES_W          = 20;
    localparam int BETA_W         = 14;
    localparam int T0_W           = 15;
    localparam int TEMP_W         = 15;
    localparam int CFG_W          = 20;
    localparam int IDX_W          = 3;

    // derived datapath widths
    localparam int PROD_W  = CODE_BITS + RES_W;
    localparam int EXP_W   = $clog2(PROD_W);
    localparam int LG_W    = EXP_W + FRAC_BITS;
    localparam int S_W     = LG_W + 3;
    localparam int K0_W    = 16;
    localparam int KB_W    = K0_W + BETA_W;
    localparam int KL_W    = K0_W + 1 + S_W;
    localparam int D_W     = KL_W + 2;
    localparam int QB      = 16;
    localparam int NUM_W   = D_W + QB + 2;
    localparam int LN2_W   = 30;

    // constants
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int KELVIN_CENTI = 27315;
    localparam int TEMP_LOW     = -5500;
    localparam int TEMP_HIGH    = 15000;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SHUNT = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FULL_SCALE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SERIES_RES   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHUNT_RES    = 3'd2;
    localparam logic [IDX_W-1:0] REG_NOMINAL_RES  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BETA_VALUE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_NOMINAL_TEMP = 3'd5;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [CODE_BITS-1:0] fs;
        logic [RES_W-1:0]     rs;
        logic [RES_W-1:0]     rsh;
        logic [RES_W-1:0]     r0;
        logic [BETA_W-1:0]    b;
        logic [K0_W-1:0]      k0;
    } cfg_t;

    // log stage output
    typedef struct packed {
        logic                  valid;
        logic [1:0]            status;
        logic signed [S_W-1:0] s;
    } logsum_t;

    // reciprocal stage output, divider input
    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic             hi;
        logic [NUM_W-1:0] numer;
        logic [NUM_W-1:0] dvs;
    } recip_t;

    // divider output
    typedef struct packed {
        logic          valid;
        logic [1:0]    status;
        logic          hi;
        logic [QB-1:0] q;
    } quot_t;

    typedef logic [FRAC_BITS-1:0] log_tab_t [TAB_SIZE];

    // log2(1 + k/2^LOG_TABLE_BITS) by repeated squaring in Q1.30
    function automatic log_tab_t build_log_tab();
        log_tab_t             t;
        logic [63:0]          y;
        logic [FRAC_BITS-1:0] r;
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            y = 64'(TAB_SIZE + k) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int i = 1; i <= FRAC_BITS; i++)
            begin
                y = (y * y) >> 30;
                if (y >= 64'h8000_0000)
                begin
                    y = y >> 1;
                    r[FRAC_BITS-i] = 1'b1;
                end
            end
            t[k] = r;
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

    // position of the leading one, zero for zero
    function automatic logic [EXP_W-1:0] lead_pos(logic [PROD_W-1:0] x);
        logic [EXP_W-1:0] p;
        p = '0;
        for (int j = 0; j < PROD_W; j++)
        begin
            if (x[j])
                p = EXP_W'(j);
        end
        return p;
    endfunction

    // table index: the bits just below the leading one
    function automatic logic [LOG_TABLE_BITS-1:0] mant_idx(logic [PROD_W-1:0] x,
                                                           logic [EXP_W-1:0] e);
        logic [PROD_W+LOG_TABLE_BITS-1:0] w;
        w = {x, {LOG_TABLE_BITS{1'b0}}} >> e;
        return w[LOG_TABLE_BITS-1:0];
    endfunction

endpackage

// File: hdl/ntc_cfg.sv
// ----------------------------------------------------------------------------
// ntc_cfg
// Configuration register file; presents cleaned-up values to the datapath.
// ----------------------------------------------------------------------------
module ntc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ntc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ntc_pkg::CFG_W-1:0]   cfg_data,
    output ntc_pkg::cfg_t               cfg
);

    logic [15:0]                    full_scale_reg;
    logic [ntc_pkg::RES_W-1:0]      series_res_reg;
    logic [ntc_pkg::RES_W-1:0]      shunt_res_reg;
    logic [ntc_pkg::RES_W-1:0]      nominal_res_reg;
    logic [ntc_pkg::BETA_W-1:0]     beta_value_reg;
    logic [ntc_pkg::T0_W-1:0]       nominal_temp_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg   <= 16'd4095;
            series_res_reg   <= 20'd10000;
            shunt_res_reg    <= '0;
            nominal_res_reg  <= 20'd10000;
            beta_value_reg   <= 14'd3950;
            nominal_temp_reg <= 15'd2500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ntc_pkg::REG_FULL_SCALE:   full_scale_reg   <= cfg_data[15:0];
                ntc_pkg::REG_SERIES_RES:   series_res_reg   <= cfg_data;
                ntc_pkg::REG_SHUNT_RES:    shunt_res_reg    <= cfg_data;
                ntc_pkg::REG_NOMINAL_RES:  nominal_res_reg  <= cfg_data;
                ntc_pkg::REG_BETA_VALUE:   beta_value_reg   <= cfg_data[13:0];
                ntc_pkg::REG_NOMINAL_TEMP: nominal_temp_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // zero series and nominal resistances and zero beta count as one, t0 moved to centikelvin
    always_comb
    begin
        cfg.fs  = full_scale_reg[ntc_pkg::CODE_BITS-1:0];
        cfg.rs  = (series_res_reg == '0) ? ntc_pkg::RES_W'(1) : series_res_reg;
        cfg.rsh = shunt_res_reg;
        cfg.r0  = (nominal_res_reg == '0) ? ntc_pkg::RES_W'(1) : nominal_res_reg;
        cfg.b   = (beta_value_reg == '0) ? ntc_pkg::BETA_W'(1) : beta_value_reg;
        cfg.k0  = ntc_pkg::K0_W'(ntc_pkg::K0_W'(signed'(nominal_temp_reg))
                  + ntc_pkg::K0_W'(ntc_pkg::KELVIN_CENTI));
    end

endmodule

// File: hdl/ntc_logsum.sv
// ----------------------------------------------------------------------------
// ntc_logsum
// Divider products, status, and the sum of base-2 logs (three stages).
// ----------------------------------------------------------------------------
module ntc_logsum
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [ntc_pkg::CODE_BITS-1:0]  v,
    input  ntc_pkg::cfg_t                  cfg,
    output ntc_pkg::logsum_t               out
);

    localparam int PW = ntc_pkg::PROD_W;
    localparam int NOPS = 5;

    // stage 1
    logic                          valid1_reg;
    logic [ntc_pkg::CODE_BITS-1:0] v1_reg, den1_reg;
    logic [PW-1:0]                 num1_reg, prod1_reg;
    logic                          over1_reg, zero1_reg;

    // stage 2
    logic                          valid2_reg;
    logic [1:0]                    status2_reg;
    logic [ntc_pkg::EXP_W-1:0]     e2_reg [NOPS];
    logic [ntc_pkg::LOG_TABLE_BITS-1:0] k2_reg [NOPS];
    logic [PW-1:0]                 ops [NOPS];
    logic                          shunt_on;
    logic                          sh_bad;
    logic [1:0]                    status_next;

    // stage 3
    logic                          valid3_reg;
    logic [1:0]                    status3_reg;
    logic signed [ntc_pkg::S_W-1:0] s3_reg, s_next;
    logic [ntc_pkg::LG_W-1:0]      lg [NOPS];

    // stage 1: divider products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else if (en)
            valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg    <= v;
            den1_reg  <= cfg.fs - v;
            num1_reg  <= PW'(v) * PW'(cfg.rs);
            prod1_reg <= PW'(cfg.rsh) * PW'(cfg.fs - v);
            over1_reg <= (v >= cfg.fs);
            zero1_reg <= (v == '0);
        end
    end

    // stage 2: status and log operand normalization
    assign shunt_on = (cfg.rsh != '0);
    assign sh_bad   = shunt_on && (num1_reg >= prod1_reg);

    always_comb
    begin
        priority if (over1_reg)
            status_next = ntc_pkg::ST_OVER;
        else if (zero1_reg)
            status_next = ntc_pkg::ST_ZERO;
        else if (sh_bad)
            status_next = ntc_pkg::ST_SHUNT;
        else
            status_next = ntc_pkg::ST_OK;
        ops[0] = PW'(v1_reg);
        ops[1] = PW'(cfg.rs);
        ops[2] = PW'(cfg.rsh);
        ops[3] = shunt_on ? (prod1_reg - num1_reg) : PW'(den1_reg);
        ops[4] = PW'(cfg.r0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else if (en)
            valid2_reg <= valid1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status2_reg <= status_next;
            for (int i = 0; i < NOPS; i++)
            begin
                e2_reg[i] <= ntc_pkg::lead_pos(ops[i]);
                k2_reg[i] <= ntc_pkg::mant_idx(ops[i], ntc_pkg::lead_pos(ops[i]));
            end
        end
    end

    // stage 3: table lookup and log sum
    always_comb
    begin
        for (int i = 0; i < NOPS; i++)
            lg[i] = {e2_reg[i], ntc_pkg::LOG_TAB[k2_reg[i]]};
        s_next = ntc_pkg::S_W'(lg[0]) + ntc_pkg::S_W'(lg[1])
               - ntc_pkg::S_W'(lg[3]) - ntc_pkg::S_W'(lg[4]);
        if (shunt_on)
            s_next = s_next + ntc_pkg::S_W'(lg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid3_reg <= 1'b0;
        else if (en)
            valid3_reg <= valid2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status3_reg <= status2_reg;
            s3_reg      <= s_next;
        end
    end

    assign out.valid  = valid3_reg;
    assign out.status = status3_reg;
    assign out.s      = s3_reg;

endmodule

// File: hdl/ntc_recip.sv
// ----------------------------------------------------------------------------
// ntc_recip
// Natural log scaling and the Beta equation numerator and denominator
// (three stages).
// ----------------------------------------------------------------------------
module ntc_recip
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ntc_pkg::logsum_t  in,
    input  ntc_pkg::cfg_t     cfg,
    output ntc_pkg::recip_t   out
);

    localparam int SW = ntc_pkg::S_W;
    localparam int NW = ntc_pkg::NUM_W;
    localparam int DW = ntc_pkg::D_W;

    // stage 4
    logic                    valid4_reg;
    logic [1:0]              status4_reg;
    logic signed [SW-1:0]    l4_reg;
    logic [ntc_pkg::KB_W-1:0] kb4_reg;
    logic [SW-1:0]           mag;
    logic [SW+ntc_pkg::LN2_W-1:0] mag_ln;
    logic [SW-1:0]           l_mag;

    // stage 5
    logic                    valid5_reg;
    logic [1:0]              status5_reg;
    logic signed [DW-1:0]    d5_reg;
    logic [NW-1:0]           n5_reg;
    logic signed [ntc_pkg::KL_W-1:0] kl;
    logic [DW-1:0]           b_term;

    // stage 6
    logic                    valid6_reg;
    logic [1:0]              status6_reg;
    logic                    hi6_reg;
    logic [NW-1:0]           numer6_reg, dvs6_reg;
    logic [NW-1:0]           numer, dvs;

    // stage 4: ln from log2, and k0*b
    always_comb
    begin
        mag    = in.s[SW-1] ? SW'(-in.s) : SW'(in.s);
        mag_ln = (SW + ntc_pkg::LN2_W)'(mag) * (SW + ntc_pkg::LN2_W)'(ntc_pkg::LN2_Q30);
        l_mag  = mag_ln[SW+ntc_pkg::LN2_W-1:ntc_pkg::LN2_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid4_reg <= 1'b0;
        else if (en)
            valid4_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status4_reg <= in.status;
            l4_reg      <= in.s[SW-1] ? -signed'(l_mag) : signed'(l_mag);
            kb4_reg     <= ntc_pkg::KB_W'(cfg.k0) * ntc_pkg::KB_W'(cfg.b);
        end
    end

    // stage 5: denominator 100*b*2^f + k0*l, numerator 100*k0*b*2^f
    always_comb
    begin
        kl     = ntc_pkg::KL_W'(signed'({1'b0, cfg.k0})) * ntc_pkg::KL_W'(l4_reg);
        b_term = (DW'(cfg.b) * DW'(100)) << ntc_pkg::FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid5_reg <= 1'b0;
        else if (en)
            valid5_reg <= valid4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status5_reg <= status4_reg;
            d5_reg      <= signed'(b_term) + DW'(kl);
            n5_reg      <= (NW'(kb4_reg) * NW'(100)) << ntc_pkg::FRAC_BITS;
        end
    end

    // stage 6: rounding bias and quotient range check
    always_comb
    begin
        dvs   = NW'(unsigned'(d5_reg));
        numer = n5_reg + NW'(unsigned'(d5_reg[DW-1:1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid6_reg <= 1'b0;
        else if (en)
            valid6_reg <= valid5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status6_reg <= status5_reg;
            hi6_reg     <= (d5_reg <= 0) || (numer >= (dvs << ntc_pkg::QB));
            numer6_reg  <= numer;
            dvs6_reg    <= dvs;
        end
    end

    assign out.valid  = valid6_reg;
    assign out.status = status6_reg;
    assign out.hi     = hi6_reg;
    assign out.numer  = numer6_reg;
    assign out.dvs    = dvs6_reg;

endmodule

// File: hdl/ntc_div.sv
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ntc_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  ntc_pkg::recip_t  in,
    output ntc_pkg::quot_t   out
);

    localparam int QB = ntc_pkg::QB;
    localparam int NW = ntc_pkg::NUM_W;

    logic          valid_reg  [QB];
    logic [1:0]    status_reg [QB];
    logic          hi_reg     [QB];
    logic [NW-1:0] rem_reg    [QB];
    logic [NW-1:0] dvs_reg    [QB];
    logic [QB-1:0] q_reg      [QB];

    // stage j settles quotient bit QB-1-j
    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic          p_valid;
        logic [1:0]    p_status;
        logic          p_hi;
        logic [NW-1:0] p_rem, p_dvs, trial;
        logic [QB-1:0] p_q;
        logic          take;

        if (j == 0)
        begin : g_first
            assign p_valid  = in.valid;
            assign p_status = in.status;
            assign p_hi     = in.hi;
            assign p_rem    = in.numer;
            assign p_dvs    = in.dvs;
            assign p_q      = '0;
        end
        else
        begin : g_next
            assign p_valid  = valid_reg[j-1];
            assign p_status = status_reg[j-1];
            assign p_hi     = hi_reg[j-1];
            assign p_rem    = rem_reg[j-1];
            assign p_dvs    = dvs_reg[j-1];
            assign p_q      = q_reg[j-1];
        end

        assign trial = p_dvs << (QB - 1 - j);
        assign take  = (p_rem >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= p_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                status_reg[j] <= p_status;
                hi_reg[j]     <= p_hi;
                dvs_reg[j]    <= p_dvs;
                rem_reg[j]    <= take ? (p_rem - trial) : p_rem;
                q_reg[j]      <= p_q | (take ? (QB'(1) << (QB - 1 - j)) : '0);
            end
        end
    end

    assign out.valid  = valid_reg[QB-1];
    assign out.status = status_reg[QB-1];
    assign out.hi     = hi_reg[QB-1];
    assign out.q      = q_reg[QB-1];

endmodule

// File: hdl/ntc_divider_beta_temperature.sv
// ----------------------------------------------------------------------------
// ntc_divider_beta_temperature
// Thermistor temperature from a divider code via the Beta equation.
// ----------------------------------------------------------------------------
// One sample enters per clock while in_stall is low: three stages solve the
// divider and sum the base-2 logs, three form the Beta equation terms,
// sixteen stages of the quotient divider produce one centikelvin bit each,
// and one output register holds the result. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so in_stall follows out_stall while a result waits. Temperature is in
// centidegrees Celsius, clamped to -5500..15000; status is 0 ok, 1 code at or
// above full scale, 2 code zero, 3 shunt exceeded, and temperature is 0 for
// any nonzero status. Configure only while the pipeline is empty.
module ntc_divider_beta_temperature
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ntc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [ntc_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         sample_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ntc_pkg::TEMP_W-1:0]   temperature,
    output logic [1:0]                          status
);

    ntc_pkg::cfg_t    cfg;
    ntc_pkg::logsum_t ls;
    ntc_pkg::recip_t  rc;
    ntc_pkg::quot_t   qt;
    logic             en;

    logic                               out_valid_reg;
    logic signed [ntc_pkg::TEMP_W-1:0]  temp_reg, temp_next;
    logic [1:0]                         status_reg;
    logic signed [ntc_pkg::QB+1:0]      t_c;

    // pipeline moves when the output register can take a transfer
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    ntc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ntc_logsum u_logsum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .v        (sample_code[ntc_pkg::CODE_BITS-1:0]),
        .cfg      (cfg),
        .out      (ls)
    );

    ntc_recip u_recip
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in    (ls),
        .cfg   (cfg),
        .out   (rc)
    );

    ntc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in    (rc),
        .out   (qt)
    );

    // kelvin to celsius with saturation
    always_comb
    begin
        t_c = signed'((ntc_pkg::QB + 2)'(qt.q))
            - (ntc_pkg::QB + 2)'(ntc_pkg::KELVIN_CENTI);
        priority if (qt.status != ntc_pkg::ST_OK)
            temp_next = '0;
        else if (qt.hi || t_c > (ntc_pkg::QB + 2)'(ntc_pkg::TEMP_HIGH))
            temp_next = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HIGH);
        else if (t_c < signed'((ntc_pkg::QB + 2)'(ntc_pkg::TEMP_LOW)))
            temp_next = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_LOW);
        else
            temp_next = t_c[ntc_pkg::TEMP_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= qt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg   <= temp_next;
            status_reg <= qt.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

    // error results carry zero temperature
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ntc_pkg::ST_OK |-> temperature == '0)
        else $error("nonzero temperature with error status");

    // results stay inside the clamp range
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature >= -16'sd5500) && (temperature <= 16'sd15000))
        else $error("temperature outside clamp range");

    // a stalled output holds the whole pipeline
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output is stalled");

endmodule

// File: tb/ntc_divider_beta_temperature_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_divider_beta_temperature_tb
// Drives divider codes through the thermistor pipeline under several register
// settings with random gaps and output stalls. A local fixed-point model of
// the divider solve, log sums and Beta equation predicts every result, and
// each result is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module ntc_divider_beta_temperature_tb;

    localparam int LATENCY     = 23;
    localparam int CYCLE_LIMIT = 400000;

    // one code waiting to be driven
    typedef struct {
        logic [15:0] code;
    } sample_t;

    typedef struct {
        logic [ntc_pkg::TEMP_W-1:0] temp;
        logic [1:0]                 st;
    } reading_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ntc_pkg::IDX_W-1:0] cfg_index;
    logic [ntc_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [15:0] sample_code;
    logic out_valid;
    logic out_stall;
    logic signed [ntc_pkg::TEMP_W-1:0] temperature;
    logic [1:0] status;

    ntc_divider_beta_temperature uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_code(sample_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .temperature(temperature),
        .status(status)
    );

    // local copy of the registers
    logic [15:0] m_fs;
    logic [19:0] m_rs;
    logic [19:0] m_rsh;
    logic [19:0] m_r0;
    logic [13:0] m_beta;
    logic [14:0] m_t0;

    logic [15:0] log_frac [256];

    sample_t  pending_codes[$];
    reading_t expected_readings[$];
    int       errors;
    int       cycles;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // log2 mantissa table by repeated squaring in Q1.30
    function automatic void fill_log_frac();
        logic [63:0] y;
        logic [15:0] r;
        for (int k = 0; k < 256; k++)
        begin
            y = 64'(256 + k) << 22;
            r = '0;
            for (int i = 1; i <= 16; i++)
            begin
                y = (y * y) >> 30;
                if (y >= 64'h8000_0000)
                begin
                    y = y >> 1;
                    r[16-i] = 1'b1;
                end
            end
            log_frac[k] = r;
        end
    endfunction

    // log2 in Q.16 of a positive integer
    function automatic longint log2_q16(longint unsigned x);
        int e;
        longint unsigned k;
        e = 0;
        if (x == 0)
            x = 1;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        if (e >= 8)
            k = (x >> (e - 8)) & 8'hFF;
        else
            k = (x << (8 - e)) & 8'hFF;
        return (longint'(e) <<< 16) + longint'(log_frac[k]);
    endfunction

    // expected temperature and status for one code
    function automatic reading_t predict_reading(logic [15:0] v);
        reading_t res;
        longint unsigned rs, r0, b, num, den, prod, mag, n, tc, fs;
        longint s, k0, l, d, t;
        bit ok;
        res.temp = '0;
        res.st = ntc_pkg::ST_OK;
        fs = m_fs;
        if (v >= fs)
            res.st = ntc_pkg::ST_OVER;
        else if (v == 0)
            res.st = ntc_pkg::ST_ZERO;
        else
        begin
            rs = (m_rs == 0) ? 1 : m_rs;
            r0 = (m_r0 == 0) ? 1 : m_r0;
            b = (m_beta == 0) ? 1 : m_beta;
            num = v * rs;
            den = fs - v;
            ok = 1'b1;
            s = 0;
            if (m_rsh != 0)
            begin
                prod = longint'(m_rsh) * den;
                if (num >= prod)
                begin
                    res.st = ntc_pkg::ST_SHUNT;
                    ok = 1'b0;
                end
                else
                    s = log2_q16(v) + log2_q16(rs) + log2_q16(m_rsh)
                        - log2_q16(prod - num) - log2_q16(r0);
            end
            else
                s = log2_q16(v) + log2_q16(rs) - log2_q16(den) - log2_q16(r0);
            if (ok)
            begin
                k0 = longint'($signed(m_t0)) + ntc_pkg::KELVIN_CENTI;
                mag = (s < 0) ? -s : s;
                mag = (mag * 744261118) >> 30;
                l = (s < 0) ? -longint'(mag) : longint'(mag);
                d = longint'((100 * b) << 16) + k0 * l;
                if (d <= 0)
                    t = ntc_pkg::TEMP_HIGH;
                else
                begin
                    n = (100 * longint'(k0) * b) << 16;
                    tc = (n + longint'(d) / 2) / longint'(d);
                    t = longint'(tc) - ntc_pkg::KELVIN_CENTI;
                    if (t > ntc_pkg::TEMP_HIGH)
                        t = ntc_pkg::TEMP_HIGH;
                    if (t < ntc_pkg::TEMP_LOW)
                        t = ntc_pkg::TEMP_LOW;
                end
                res.temp = t[ntc_pkg::TEMP_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // short gap mostly, long now and then
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: issues transfers from the pending queue
    int drive_gap;
    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_code <= '0;
            drive_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                expected_readings.push_back(predict_reading(sample_code));
            if (drive_gap > 0)
            begin
                in_valid <= 1'b0;
                drive_gap <= drive_gap - 1;
            end
            else if (pending_codes.size() > 0)
            begin
                nxt = pending_codes.pop_front();
                sample_code <= nxt.code;
                in_valid <= 1'b1;
                drive_gap <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each result transfer and throttles the output
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected result", temperature, 0);
                else
                begin
                    reading_t w;
                    w = expected_readings.pop_front();
                    if (status !== w.st)
                        report_mismatch("status", status, w.st);
                    if (temperature !== w.temp)
                        report_mismatch("temperature", temperature, $signed(w.temp));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left <= gap_len();
                out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [ntc_pkg::IDX_W-1:0] idx, logic [ntc_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ntc_pkg::REG_FULL_SCALE:   m_fs = val[15:0];
            ntc_pkg::REG_SERIES_RES:   m_rs = val[19:0];
            ntc_pkg::REG_SHUNT_RES:    m_rsh = val[19:0];
            ntc_pkg::REG_NOMINAL_RES:  m_r0 = val[19:0];
            ntc_pkg::REG_BETA_VALUE:   m_beta = val[13:0];
            ntc_pkg::REG_NOMINAL_TEMP: m_t0 = val[14:0];
            default: ;
        endcase
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (pending_codes.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic push_code(logic [15:0] c);
        sample_t s;
        s.code = c;
        pending_codes.push_back(s);
    endtask

    // codes mostly inside the active span, some at the edges
    function automatic logic [15:0] rand_code();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return 16'($urandom_range(0, 65535));
        if (p == 1)
            return m_fs;
        if (p == 2)
            return 16'(0);
        if (m_fs <= 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, m_fs - 1));
    endfunction

    task automatic load_setting(int fs, int rs, int rsh, int r0, int b, int t0);
        write_reg(ntc_pkg::REG_FULL_SCALE, ntc_pkg::CFG_W'(fs));
        write_reg(ntc_pkg::REG_SERIES_RES, ntc_pkg::CFG_W'(rs));
        write_reg(ntc_pkg::REG_SHUNT_RES, ntc_pkg::CFG_W'(rsh));
        write_reg(ntc_pkg::REG_NOMINAL_RES, ntc_pkg::CFG_W'(r0));
        write_reg(ntc_pkg::REG_BETA_VALUE, ntc_pkg::CFG_W'(b));
        write_reg(ntc_pkg::REG_NOMINAL_TEMP, ntc_pkg::CFG_W'(t0 & 16'h7FFF));
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            push_code(rand_code());
        drain();
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fill_log_frac();
        m_fs = 4095;
        m_rs = 10000;
        m_rsh = 0;
        m_r0 = 10000;
        m_beta = 3950;
        m_t0 = 2500;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, edges of the code range
        push_code(16'd0);
        push_code(16'd1);
        push_code(16'd2047);
        push_code(16'd2048);
        push_code(16'd4094);
        push_code(16'd4095);
        push_code(16'hFFFF);
        push_code(16'h5555);
        push_code(16'hAAAA);
        push_code(16'd100);
        push_code(16'd3900);
        drain();

        // directed: shunt present, exceeded and not, extreme low resistance
        load_setting(65535, 1000000, 1000, 1, 10000, 15000);
        push_code(16'd1);
        push_code(16'd2);
        push_code(16'd60000);
        push_code(16'd65534);
        push_code(16'd65535);
        drain();
        load_setting(65535, 1, 1000000, 1000000, 1, -4000);
        push_code(16'd1);
        push_code(16'd32768);
        push_code(16'd65534);
        drain();
        // zero series, nominal and beta registers taken as one, full scale zero
        load_setting(0, 0, 0, 0, 0, 0);
        push_code(16'd0);
        push_code(16'd7);
        drain();
        // out of range index is ignored
        write_reg(3'd7, 20'hFFFFF);
        write_reg(3'd6, 20'h12345);
        load_setting(1, 1, 0, 1, 1, 0);
        push_code(16'd0);
        push_code(16'd1);
        drain();

        // random phases across settings
        load_setting(4095, 10000, 0, 10000, 3950, 2500);
        random_phase(150);
        load_setting(65535, 10000, 100000, 10000, 3435, 2500);
        random_phase(150);
        load_setting(1023, 4700, 0, 100000, 4250, -4000);
        random_phase(120);
        load_setting(65535, 1000000, 0, 1000000, 10000, 15000);
        random_phase(120);
        load_setting(16383, 1, 1, 1, 1, 0);
        random_phase(60);
        for (int ph = 0; ph < 6; ph++)
        begin
            load_setting($urandom_range(1, 65535), $urandom_range(1, 1000000),
                         ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1000000),
                         $urandom_range(1, 1000000), $urandom_range(1, 10000),
                         $urandom_range(0, 19000) - 4000);
            random_phase(50);
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/ntc_pkg.sv
hdl/ntc_cfg.sv
hdl/ntc_logsum.sv
hdl/ntc_recip.sv
hdl/ntc_div.sv
hdl/ntc_divider_beta_temperature.sv
tb/ntc_divider_beta_temperature_tb.sv
